// File: hdl/ipcls_pkg.sv
// Package for the IP address text classifier.
// Holds character codes, section limits and the result kind encoding.
// No dependencies.
package ipcls_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F   = 8'h46;

   localparam int V4_VALUE_W = 10;
   localparam int V4_DIGIT_W = 3;
   localparam int V4_COUNT_W = 3;
   localparam int V6_DIGIT_W = 3;
   localparam int V6_COUNT_W = 4;

   localparam logic [V4_VALUE_W-1:0] V4_MAX_VALUE  = 10'd255;
   localparam logic [V4_DIGIT_W-1:0] V4_MAX_DIGITS = 3'd3;
   localparam logic [V4_COUNT_W-1:0] V4_SECTIONS   = 3'd4;
   localparam logic [V4_COUNT_W-1:0] V4_COUNT_MAX  = 3'd7;
   localparam logic [V6_DIGIT_W-1:0] V6_MAX_DIGITS = 3'd4;
   localparam logic [V6_COUNT_W-1:0] V6_SECTIONS   = 4'd8;
   localparam logic [V6_COUNT_W-1:0] V6_COUNT_MAX  = 4'd15;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_IPV4 = 2'd1,
      KIND_IPV6 = 2'd2
   } kind_type;

endpackage

// File: hdl/ipcls_v4_check.sv
// Dotted-quad checker: tracks sections, digits, value and leading zero.
// Gives a pass flag for the string ending with the current character.
// Depends on ipcls_pkg.
module ipcls_v4_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [ipcls_pkg::CHAR_W-1:0] char_code,
   input  logic                         is_last,
   output logic                         pass
);

   logic                               alive_ff, alive_in;
   logic [ipcls_pkg::V4_COUNT_W-1:0]   count_ff, count_in;
   logic [ipcls_pkg::V4_DIGIT_W-1:0]   digits_ff, digits_in;
   logic [ipcls_pkg::V4_VALUE_W-1:0]   value_ff, value_in;
   logic                               lzero_ff, lzero_in;

   logic                               f_alive;
   logic [ipcls_pkg::V4_COUNT_W-1:0]   f_count;
   logic [ipcls_pkg::V4_DIGIT_W-1:0]   f_digits;
   logic [ipcls_pkg::V4_VALUE_W-1:0]   f_value;
   logic                               f_lzero;
   logic                               c_alive;
   logic [ipcls_pkg::V4_COUNT_W-1:0]   c_count;
   logic                               is_dot;
   logic                               is_digit;
   logic [3:0]                         digit;

   assign is_dot   = (char_code == ipcls_pkg::CHAR_DOT);
   assign is_digit = (char_code >= ipcls_pkg::CHAR_ZERO) && (char_code <= ipcls_pkg::CHAR_NINE);
   assign digit    = 4'(char_code - ipcls_pkg::CHAR_ZERO);

   // feed the character
   always_comb begin
      f_alive  = alive_ff;
      f_count  = count_ff;
      f_digits = digits_ff;
      f_value  = value_ff;
      f_lzero  = lzero_ff;
      if (alive_ff) begin
         priority if (is_dot) begin
            if ((digits_ff == '0) || (value_ff > ipcls_pkg::V4_MAX_VALUE)) begin
               f_alive = 1'b0;
            end else begin
               if (count_ff < ipcls_pkg::V4_COUNT_MAX) begin
                  f_count = count_ff + 1'b1;
               end
               f_digits = '0;
               f_value  = '0;
               f_lzero  = 1'b0;
            end
         end else if (is_digit) begin
            if ((digits_ff >= ipcls_pkg::V4_MAX_DIGITS) || lzero_ff) begin
               f_alive = 1'b0;
            end else begin
               if ((digits_ff == '0) && (char_code == ipcls_pkg::CHAR_ZERO)) begin
                  f_lzero = 1'b1;
               end
               f_value  = ipcls_pkg::V4_VALUE_W'((value_ff * 10'd10)
                                                 + {6'd0, digit});
               f_digits = digits_ff + 1'b1;
            end
         end else begin
            f_alive = 1'b0;
         end
      end
   end

   // close the open section at end of string
   always_comb begin
      c_alive = f_alive;
      c_count = f_count;
      if (f_alive) begin
         if ((f_digits == '0) || (f_value > ipcls_pkg::V4_MAX_VALUE)) begin
            c_alive = 1'b0;
         end else if (f_count < ipcls_pkg::V4_COUNT_MAX) begin
            c_count = f_count + 1'b1;
         end
      end
   end

   assign pass = c_alive && (c_count == ipcls_pkg::V4_SECTIONS);

   always_comb begin
      alive_in  = alive_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      value_in  = value_ff;
      lzero_in  = lzero_ff;
      if (step) begin
         if (is_last) begin
            alive_in  = 1'b1;
            count_in  = '0;
            digits_in = '0;
            value_in  = '0;
            lzero_in  = 1'b0;
         end else begin
            alive_in  = f_alive;
            count_in  = f_count;
            digits_in = f_digits;
            value_in  = f_value;
            lzero_in  = f_lzero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff  <= 1'b1;
         count_ff  <= '0;
         digits_ff <= '0;
         value_ff  <= '0;
         lzero_ff  <= 1'b0;
      end else begin
         alive_ff  <= alive_in;
         count_ff  <= count_in;
         digits_ff <= digits_in;
         value_ff  <= value_in;
         lzero_ff  <= lzero_in;
      end
   end

endmodule

// File: hdl/ipcls_v6_check.sv
// Colon-hex checker: tracks sections and hex digits per section.
// Gives a pass flag for the string ending with the current character.
// Depends on ipcls_pkg.
module ipcls_v6_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [ipcls_pkg::CHAR_W-1:0] char_code,
   input  logic                         is_last,
   output logic                         pass
);

   logic                               alive_ff, alive_in;
   logic [ipcls_pkg::V6_COUNT_W-1:0]   count_ff, count_in;
   logic [ipcls_pkg::V6_DIGIT_W-1:0]   digits_ff, digits_in;

   logic                               f_alive;
   logic [ipcls_pkg::V6_COUNT_W-1:0]   f_count;
   logic [ipcls_pkg::V6_DIGIT_W-1:0]   f_digits;
   logic                               c_alive;
   logic [ipcls_pkg::V6_COUNT_W-1:0]   c_count;
   logic                               is_colon;
   logic                               is_hex;

   assign is_colon = (char_code == ipcls_pkg::CHAR_COLON);
   assign is_hex   = ((char_code >= ipcls_pkg::CHAR_ZERO) && (char_code <= ipcls_pkg::CHAR_NINE))
                  || ((char_code >= ipcls_pkg::CHAR_LO_A) && (char_code <= ipcls_pkg::CHAR_LO_F))
                  || ((char_code >= ipcls_pkg::CHAR_UP_A) && (char_code <= ipcls_pkg::CHAR_UP_F));

   always_comb begin
      f_alive  = alive_ff;
      f_count  = count_ff;
      f_digits = digits_ff;
      if (alive_ff) begin
         priority if (is_colon) begin
            if (digits_ff == '0) begin
               f_alive = 1'b0;
            end else begin
               if (count_ff < ipcls_pkg::V6_COUNT_MAX) begin
                  f_count = count_ff + 1'b1;
               end
               f_digits = '0;
            end
         end else if (is_hex) begin
            if (digits_ff >= ipcls_pkg::V6_MAX_DIGITS) begin
               f_alive = 1'b0;
            end else begin
               f_digits = digits_ff + 1'b1;
            end
         end else begin
            f_alive = 1'b0;
         end
      end
   end

   always_comb begin
      c_alive = f_alive;
      c_count = f_count;
      if (f_alive) begin
         if (f_digits == '0) begin
            c_alive = 1'b0;
         end else if (f_count < ipcls_pkg::V6_COUNT_MAX) begin
            c_count = f_count + 1'b1;
         end
      end
   end

   assign pass = c_alive && (c_count == ipcls_pkg::V6_SECTIONS);

   always_comb begin
      alive_in  = alive_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      if (step) begin
         if (is_last) begin
            alive_in  = 1'b1;
            count_in  = '0;
            digits_in = '0;
         end else begin
            alive_in  = f_alive;
            count_in  = f_count;
            digits_in = f_digits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff  <= 1'b1;
         count_ff  <= '0;
         digits_ff <= '0;
      end else begin
         alive_ff  <= alive_in;
         count_ff  <= count_in;
         digits_ff <= digits_in;
      end
   end

endmodule

// File: hdl/ip_address_text_classifier.sv
// IP address text classifier, top level: input register, IPv4 and IPv6
// checkers side by side, result register. Depends on ipcls_pkg,
// ipcls_v4_check and ipcls_v6_check.
// The last character goes through the input register, then the result register.
// Throughput: one character per cycle; a result held by rsp_stall holds the input stage.
// Reset: synchronous; clears both checkers to the start of a string, empties stages.
module ip_address_text_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ipcls_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ipcls_pkg::KIND_W-1:0]        rsp_address_kind
);

   logic                                in_valid_ff, in_valid_in;
   logic [ipcls_pkg::CHAR_W-1:0]        in_char_ff, in_char_in;
   logic                                in_last_ff, in_last_in;
   logic                                out_valid_ff, out_valid_in;
   ipcls_pkg::kind_type                 out_kind_ff, out_kind_in;

   logic                                advance;
   logic                                req_take;
   logic                                v4_pass;
   logic                                v6_pass;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ipcls_v4_check u_v4 (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .pass      (v4_pass)
   );

   ipcls_v6_check u_v6 (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .pass      (v6_pass)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_code;
         in_last_in  = req_is_last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         priority if (v4_pass) begin
            out_kind_in = ipcls_pkg::KIND_IPV4;
         end else if (v6_pass) begin
            out_kind_in = ipcls_pkg::KIND_IPV6;
         end else begin
            out_kind_in = ipcls_pkg::KIND_NONE;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_last_ff  <= in_last_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_address_kind = out_kind_ff;

endmodule
